// ===== hdl/msf_pkg.sv =====
// Shared types and widths for the match distance sigma filter.
// Used by the front, queue, back end and top level; depends on nothing.
package msf_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned INDEX_W = 16;
    localparam int unsigned DIST_W = 17;
    localparam int unsigned SUM_W = 23;
    localparam int unsigned SQSUM_W = 40;
    localparam int unsigned SIGMA_W = 12;
    localparam logic [SIGMA_W-1:0] SIGMA_RESET = 12'd256;
    localparam int unsigned MAX_PAIRS_DEFAULT = 64;

    // One classified pair handed from the front to the back end.
    typedef struct packed {
        logic               last;
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] second_index;
        logic [INDEX_W-1:0] first_index;
    } t_pair;

endpackage

// ===== hdl/msf_front.sv =====
// Front end: accepts a point pair and forms the floor Euclidean distance.
// Depends on msf_pkg; feeds msf_queue.
module msf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [msf_pkg::COORD_W-1:0]   i_first_x,
    input  logic [msf_pkg::COORD_W-1:0]   i_first_y,
    input  logic [msf_pkg::COORD_W-1:0]   i_second_x,
    input  logic [msf_pkg::COORD_W-1:0]   i_second_y,
    input  logic [msf_pkg::INDEX_W-1:0]   i_first_index,
    input  logic [msf_pkg::INDEX_W-1:0]   i_second_index,
    input  logic                          i_last_pair,
    input  logic                          i_full,
    output logic                          o_push,
    output msf_pkg::t_pair                o_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQ   = 2'd1;
    localparam logic [1:0] F_ROOT = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;
    localparam int unsigned RW = 36;
    localparam logic [3:0] ROOT_LAST = 4'd8;

    logic [1:0]                   r_state;
    logic [msf_pkg::COORD_W-1:0]  r_dx, r_dy;
    logic [msf_pkg::INDEX_W-1:0]  r_idx1, r_idx2;
    logic                         r_last;
    logic [RW-1:0]                r_rem, r_root, r_bit;
    logic [3:0]                   r_cnt;
    logic [RW-1:0]                n_rem, n_root, n_bit;
    logic [RW-1:0]                step_sum;
    logic                         accept;

    assign accept = start && (r_state == F_IDLE);
    assign busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_item = '{last: r_last, distance: r_root[msf_pkg::DIST_W-1:0],
                      second_index: r_idx2, first_index: r_idx1};

    // Two digit-by-digit square root steps per cycle.
    always_comb begin
        n_rem = r_rem;
        n_root = r_root;
        n_bit = r_bit;
        for (int k = 0; k < 2; k++) begin
            step_sum = n_root + n_bit;
            if (n_rem >= step_sum) begin
                n_rem = n_rem - step_sum;
                n_root = (n_root >> 1) + n_bit;
            end else begin
                n_root = n_root >> 1;
            end
            n_bit = n_bit >> 2;
        end
    end

    // Control sequence: capture, square, root, hand over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: if (accept) r_state <= F_SQ;
                F_SQ:   r_state <= F_ROOT;
                F_ROOT: if (r_cnt == ROOT_LAST) r_state <= F_PUSH;
                F_PUSH: if (!i_full) r_state <= F_IDLE;
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx <= (i_first_x >= i_second_x) ? i_first_x - i_second_x
                                              : i_second_x - i_first_x;
            r_dy <= (i_first_y >= i_second_y) ? i_first_y - i_second_y
                                              : i_second_y - i_first_y;
            r_idx1 <= i_first_index;
            r_idx2 <= i_second_index;
            r_last <= i_last_pair;
        end
        if (r_state == F_SQ) begin
            r_rem <= RW'({16'd0, r_dx} * {16'd0, r_dx})
                   + RW'({16'd0, r_dy} * {16'd0, r_dy});
            r_root <= '0;
            r_bit <= RW'(1) << 34;
            r_cnt <= '0;
        end else if (r_state == F_ROOT) begin
            r_rem <= n_rem;
            r_root <= n_root;
            r_bit <= n_bit;
            r_cnt <= r_cnt + 4'd1;
        end
    end

endmodule

// ===== hdl/msf_queue.sv =====
// Two-entry queue between the front and back ends.
// Depends on msf_pkg for the pair type.
module msf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  msf_pkg::t_pair i_item,
    input  logic           i_pop,
    output msf_pkg::t_pair o_item,
    output logic           o_full,
    output logic           o_empty
);

    msf_pkg::t_pair r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_count;

    assign o_full = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item = r_mem[r_rp];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ===== hdl/msf_back.sv =====
// Back end: stores pairs, keeps the sums and runs the sigma filter scan.
// Depends on msf_pkg; drains msf_queue and drives the result ports.
module msf_back #(
    parameter int unsigned MAX_PAIRS = msf_pkg::MAX_PAIRS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  msf_pkg::t_pair                i_item,
    output logic                          o_pop,
    input  logic [msf_pkg::SIGMA_W-1:0]   i_sigma,
    output logic                          o_valid,
    output logic [msf_pkg::INDEX_W-1:0]   o_kept_first_index,
    output logic [msf_pkg::INDEX_W-1:0]   o_kept_second_index,
    output logic [msf_pkg::DIST_W-1:0]    o_kept_distance,
    output logic                          o_overflowed,
    output logic                          o_last_kept
);

    localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
    localparam int unsigned AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int unsigned DW = msf_pkg::DIST_W;
    localparam int unsigned EW = 2 * msf_pkg::INDEX_W + DW;
    localparam int unsigned NQW = CW + msf_pkg::SQSUM_W;
    localparam int unsigned S2W = 2 * msf_pkg::SIGMA_W;
    localparam int unsigned VLW = 24;
    localparam int unsigned TW = S2W + NQW;
    localparam int unsigned AA = 31;
    localparam logic [CW-1:0] CAP = CW'(MAX_PAIRS);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_LOAD = 4'd1;
    localparam logic [3:0] B_ACC  = 4'd2;
    localparam logic [3:0] B_ST1  = 4'd3;
    localparam logic [3:0] B_ST2  = 4'd4;
    localparam logic [3:0] B_ST3  = 4'd5;
    localparam logic [3:0] B_ST4  = 4'd6;
    localparam logic [3:0] B_RD   = 4'd7;
    localparam logic [3:0] B_ND   = 4'd8;
    localparam logic [3:0] B_SUB  = 4'd9;
    localparam logic [3:0] B_MUL  = 4'd10;
    localparam logic [3:0] B_CMP  = 4'd11;
    localparam logic [3:0] B_FIN  = 4'd12;

    logic [EW-1:0]                 r_mem [MAX_PAIRS];
    logic [EW-1:0]                 r_rd;
    logic [3:0]                    r_state;
    msf_pkg::t_pair                r_cur;
    logic                          r_stored;
    logic [CW-1:0]                 r_count, r_idx;
    logic [msf_pkg::SUM_W-1:0]     r_sum;
    logic [msf_pkg::SQSUM_W-1:0]   r_sqsum;
    logic [2*DW-1:0]               r_dsq;
    logic                          r_ovf;
    logic [NQW-1:0]                r_nq, r_v;
    logic [2*msf_pkg::SUM_W-1:0]   r_ss;
    logic [S2W-1:0]                r_s2;
    logic [S2W+VLW-1:0]            r_plo;
    logic [S2W+NQW-VLW-1:0]        r_phi;
    logic [TW-1:0]                 r_t;
    logic [CW+DW-1:0]              r_nd;
    logic                          r_le;
    logic [AA-1:0]                 r_a;
    logic [2*AA-1:0]               r_a2;
    logic                          r_pend;
    logic [EW-1:0]                 r_pend_e;
    logic                          r_valid, r_lastk, r_oovf;
    logic [EW-1:0]                 r_oe;
    logic                          pass, emit;

    assign o_pop = (r_state == B_IDLE) && !i_empty;
    assign pass = r_le || (TW'(r_a2) <= r_t);
    assign emit = ((r_state == B_CMP) && pass && r_pend)
               || ((r_state == B_FIN) && r_pend);

    assign o_valid = r_valid;
    assign o_kept_first_index = r_oe[msf_pkg::INDEX_W-1:0];
    assign o_kept_second_index = r_oe[2*msf_pkg::INDEX_W-1:msf_pkg::INDEX_W];
    assign o_kept_distance = r_oe[EW-1:2*msf_pkg::INDEX_W];
    assign o_overflowed = r_oovf;
    assign o_last_kept = r_lastk;

    // Sequencer: load one pair, or on the last pair compute stats and scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_count <= '0;
            r_sum <= '0;
            r_sqsum <= '0;
            r_ovf <= 1'b0;
            r_pend <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= emit;
            unique case (r_state)
                B_IDLE: if (!i_empty) r_state <= B_LOAD;
                B_LOAD: begin
                    if (r_count < CAP) begin
                        r_sum <= r_sum + msf_pkg::SUM_W'(r_cur.distance);
                        r_count <= r_count + CW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= B_ACC;
                end
                B_ACC: begin
                    if (r_stored) r_sqsum <= r_sqsum + msf_pkg::SQSUM_W'(r_dsq);
                    r_state <= r_cur.last ? B_ST1 : B_IDLE;
                end
                B_ST1: r_state <= B_ST2;
                B_ST2: r_state <= B_ST3;
                B_ST3: r_state <= B_ST4;
                B_ST4: begin
                    r_pend <= 1'b0;
                    r_state <= (r_count == '0) ? B_FIN : B_RD;
                end
                B_RD:  r_state <= B_ND;
                B_ND:  r_state <= B_SUB;
                B_SUB: r_state <= B_MUL;
                B_MUL: r_state <= B_CMP;
                B_CMP: begin
                    if (pass) r_pend <= 1'b1;
                    r_state <= (r_idx + CW'(1) == r_count) ? B_FIN : B_RD;
                end
                B_FIN: begin
                    r_pend <= 1'b0;
                    r_count <= '0;
                    r_sum <= '0;
                    r_sqsum <= '0;
                    r_ovf <= 1'b0;
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Storage, arithmetic and result registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= i_item;
        if (r_state == B_LOAD) begin
            r_stored <= (r_count < CAP);
            r_dsq <= {{DW{1'b0}}, r_cur.distance} * {{DW{1'b0}}, r_cur.distance};
            if (r_count < CAP) begin
                r_mem[r_count[AW-1:0]] <= {r_cur.distance, r_cur.second_index,
                                           r_cur.first_index};
            end
        end
        if (r_state == B_ST1) begin
            r_nq <= NQW'(r_count) * NQW'(r_sqsum);
            r_ss <= {{msf_pkg::SUM_W{1'b0}}, r_sum} * {{msf_pkg::SUM_W{1'b0}}, r_sum};
            r_s2 <= {{msf_pkg::SIGMA_W{1'b0}}, i_sigma} * {{msf_pkg::SIGMA_W{1'b0}}, i_sigma};
        end
        if (r_state == B_ST2) begin
            r_v <= (r_nq >= NQW'(r_ss)) ? r_nq - NQW'(r_ss) : '0;
        end
        if (r_state == B_ST3) begin
            r_plo <= (S2W+VLW)'(r_s2) * (S2W+VLW)'(r_v[VLW-1:0]);
            r_phi <= (S2W+NQW-VLW)'(r_s2) * (S2W+NQW-VLW)'(r_v[NQW-1:VLW]);
        end
        if (r_state == B_ST4) begin
            r_t <= TW'(r_plo) + (TW'(r_phi) << VLW);
            r_idx <= '0;
        end
        if (r_state == B_RD) r_rd <= r_mem[r_idx[AW-1:0]];
        if (r_state == B_ND) begin
            r_nd <= (CW+DW)'(r_count) * (CW+DW)'(r_rd[EW-1:2*msf_pkg::INDEX_W]);
        end
        if (r_state == B_SUB) begin
            r_le <= (r_nd <= (CW+DW)'(r_sum));
            r_a <= AA'(r_nd - (CW+DW)'(r_sum)) << 8;
        end
        if (r_state == B_MUL) r_a2 <= {{AA{1'b0}}, r_a} * {{AA{1'b0}}, r_a};
        if (r_state == B_CMP) begin
            if (pass) r_pend_e <= r_rd;
            r_idx <= r_idx + CW'(1);
        end
        if (emit) begin
            r_oe <= r_pend_e;
            r_oovf <= r_ovf;
            r_lastk <= (r_state == B_FIN);
        end
    end

endmodule

// ===== hdl/match_distance_sigma_filter.sv =====
// Top level of the match distance sigma filter.
// Depends on msf_pkg, msf_front, msf_queue and msf_back.
//
// Usage: drive a pair on the input ports with start high; the transaction is
// taken at a clock edge where start is high and busy is low. The front end
// forms the distance by capture, square, a two-bit-per-cycle square root
// and hand-over, and takes no new pair until the result is handed to the
// queue. A two-entry queue lets the front take new pairs while the back
// end stores earlier ones or scans a set.
// On a pair with last_pair high the back end computes the set statistics,
// then tests each stored pair in turn, emitting each kept pair as a
// one-cycle transaction marked by o_valid; o_last_kept marks the final
// one. The receiver cannot stall, so results are never held. The user must
// write sigma_scale with i_cfg_we only while the block is idle; the block
// itself does not enforce this. Synchronous active-low reset empties the
// set and the queue and sets sigma_scale to 1.0.
module match_distance_sigma_filter #(
    parameter int unsigned MAX_PAIRS = msf_pkg::MAX_PAIRS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [msf_pkg::COORD_W-1:0]   i_first_x,
    input  logic [msf_pkg::COORD_W-1:0]   i_first_y,
    input  logic [msf_pkg::COORD_W-1:0]   i_second_x,
    input  logic [msf_pkg::COORD_W-1:0]   i_second_y,
    input  logic [msf_pkg::INDEX_W-1:0]   i_first_index,
    input  logic [msf_pkg::INDEX_W-1:0]   i_second_index,
    input  logic                          i_last_pair,
    input  logic                          i_cfg_we,
    input  logic [msf_pkg::SIGMA_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    output logic [msf_pkg::INDEX_W-1:0]   o_kept_first_index,
    output logic [msf_pkg::INDEX_W-1:0]   o_kept_second_index,
    output logic [msf_pkg::DIST_W-1:0]    o_kept_distance,
    output logic                          o_overflowed,
    output logic                          o_last_kept
);

    logic [msf_pkg::SIGMA_W-1:0] r_sigma;
    logic                        push, pop, full, empty;
    msf_pkg::t_pair              push_item, pop_item;

    // Sigma scale register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= msf_pkg::SIGMA_RESET;
        end else if (i_cfg_we) begin
            r_sigma <= i_cfg_data;
        end
    end

    msf_front u_front (
        .i_clk, .i_rst_n, .start, .busy,
        .i_first_x, .i_first_y, .i_second_x, .i_second_y,
        .i_first_index, .i_second_index, .i_last_pair,
        .i_full(full), .o_push(push), .o_item(push_item)
    );

    msf_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_item(push_item),
        .i_pop(pop), .o_item(pop_item), .o_full(full), .o_empty(empty)
    );

    msf_back #(.MAX_PAIRS(MAX_PAIRS)) u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_item(pop_item), .o_pop(pop),
        .i_sigma(r_sigma), .o_valid,
        .o_kept_first_index, .o_kept_second_index, .o_kept_distance,
        .o_overflowed, .o_last_kept
    );

endmodule
